// File: rtl/core/qmvm_pkg.sv
`default_nettype none

package qmvm_pkg;

    // item command codes
    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    // field widths
    localparam int COL_W   = 12;
    localparam int X_W     = 16;
    localparam int WGT_W   = 16;
    localparam int SCALE_W = 24;
    localparam int RES_W   = 32;

    // internal widths
    localparam int PROD_W  = X_W + WGT_W;
    localparam int ACC_W   = 48;
    localparam int RAM_W   = ACC_W + 1;
    localparam int HALF_W  = ACC_W / 2;
    localparam int PART_W  = HALF_W + SCALE_W;
    localparam int Q_W     = PART_W + 7;

    // conversion shifts
    localparam int INT8_SHIFT = 18;
    localparam int Q15_SHIFT  = 11;
    localparam int HI_SHIFT   = HALF_W - INT8_SHIFT;

    // limits
    localparam logic signed [WGT_W-1:0] INT8_MAX = 16'sd127;
    localparam logic signed [WGT_W-1:0] INT8_MIN = -16'sd128;
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_ACC,
        ST_MAG,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } qmvm_state_t;

    typedef struct packed {
        logic accept;
        logic prod_load;
        logic acc_write;
        logic mag_load;
        logic mul_load;
        logic sum_load;
        logic out_load;
    } qmvm_cmd_t;

    typedef struct packed {
        logic out_free;
    } qmvm_status_t;

endpackage

`default_nettype wire

// File: rtl/core/qmvm_ram.sv
`default_nettype none

module qmvm_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/qmvm_ctrl.sv
`default_nettype none

module qmvm_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    command,
    input  qmvm_pkg::qmvm_status_t  status,
    output logic                    in_ready,
    output qmvm_pkg::qmvm_cmd_t     cmd
);

    import qmvm_pkg::*;

    qmvm_state_t state_reg;
    qmvm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (command == CMD_READ) ? ST_MAG : ST_PROD;
                end
            end
            ST_PROD: state_next = ST_ACC;
            ST_ACC:  state_next = ST_IDLE;
            ST_MAG:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_PROD: cmd.prod_load = 1'b1;
            ST_ACC:  cmd.acc_write = 1'b1;
            ST_MAG:  cmd.mag_load  = 1'b1;
            ST_MUL:  cmd.mul_load  = 1'b1;
            ST_SUM:  cmd.sum_load  = 1'b1;
            ST_DONE: cmd.out_load  = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/qmvm_datapath.sv
`default_nettype none

module qmvm_datapath #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  qmvm_pkg::qmvm_cmd_t                cmd,
    output qmvm_pkg::qmvm_status_t             status,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic [qmvm_pkg::COL_W-1:0]         column,
    input  logic signed [qmvm_pkg::X_W-1:0]    x_value,
    input  logic signed [qmvm_pkg::WGT_W-1:0]  weight_value,
    input  logic                               first_row,
    input  logic signed [qmvm_pkg::SCALE_W-1:0] column_scale,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [qmvm_pkg::COL_W-1:0]         result_column,
    output logic signed [qmvm_pkg::RES_W-1:0]  result_value,
    output logic                               saturated
);

    import qmvm_pkg::*;

    localparam int COL_SPACE = 1 << COL_W;
    localparam int MEM_DEPTH = (MAX_COLUMNS < COL_SPACE) ? MAX_COLUMNS : COL_SPACE;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // mode register
    logic mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // item registers
    logic [COL_W-1:0]          col_reg;
    logic signed [X_W-1:0]     x_reg;
    logic signed [WGT_W-1:0]   w_reg;
    logic                      first_reg;
    logic signed [SCALE_W-1:0] scale_reg;
    logic                      ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            col_reg   <= column;
            x_reg     <= x_value;
            w_reg     <= weight_value;
            first_reg <= first_row;
            scale_reg <= column_scale;
            ok_reg    <= ({{(32-COL_W){1'b0}}, column} < 32'(MAX_COLUMNS));
        end
    end

    // accumulator and overflow mark storage
    logic [RAM_W-1:0] ram_rdata;
    logic [RAM_W-1:0] ram_wdata;

    qmvm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.acc_write && ok_reg),
        .waddr (col_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (column[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    logic signed [ACC_W-1:0] acc_old;
    logic                    mark_old;

    assign acc_old  = ram_rdata[ACC_W-1:0];
    assign mark_old = ram_rdata[ACC_W];

    // product, weight clamped in int8 mode
    logic signed [WGT_W-1:0]  w_eff;
    logic signed [PROD_W-1:0] prod_reg;

    always_comb
    begin
        w_eff = w_reg;
        if (mode_reg)
        begin
            if (w_reg > INT8_MAX)
            begin
                w_eff = INT8_MAX;
            end
            else if (w_reg < INT8_MIN)
            begin
                w_eff = INT8_MIN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prod_load)
        begin
            prod_reg <= x_reg * w_eff;
        end
    end

    // saturating add
    logic signed [ACC_W:0]   sum;
    logic                    sum_ovf;
    logic [ACC_W-1:0]        acc_next;
    logic                    mark_next;

    always_comb
    begin
        sum      = {acc_old[ACC_W-1], acc_old}
                 + {{(ACC_W+1-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        sum_ovf  = sum[ACC_W] ^ sum[ACC_W-1];
        if (first_reg)
        begin
            acc_next  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            mark_next = 1'b0;
        end
        else if (sum_ovf)
        begin
            acc_next  = sum[ACC_W] ? ACC_MIN : ACC_MAX;
            mark_next = 1'b1;
        end
        else
        begin
            acc_next  = sum[ACC_W-1:0];
            mark_next = mark_old;
        end
        ram_wdata = {mark_next, acc_next};
    end

    // read: magnitudes
    logic [ACC_W-1:0]   a_reg;
    logic               acc_neg_reg;
    logic               mark_reg;
    logic [SCALE_W-1:0] sm_reg;
    logic               scale_neg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mag_load)
        begin
            a_reg         <= acc_old[ACC_W-1] ? (ACC_W'(0) - acc_old) : acc_old;
            acc_neg_reg   <= acc_old[ACC_W-1];
            mark_reg      <= mark_old;
            sm_reg        <= scale_reg[SCALE_W-1] ? (SCALE_W'(0) - scale_reg) : scale_reg;
            scale_neg_reg <= scale_reg[SCALE_W-1];
        end
    end

    // read: two partial products of the scale
    logic [PART_W-1:0] hi_p_reg;
    logic [PART_W-1:0] lo_p_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            hi_p_reg <= PART_W'(a_reg[ACC_W-1:HALF_W]) * PART_W'(sm_reg);
            lo_p_reg <= PART_W'(a_reg[HALF_W-1:0]) * PART_W'(sm_reg);
        end
    end

    // read: rounded magnitude
    logic [PART_W-1:0] lo_round;
    logic [ACC_W-1:0]  a_round;
    logic [Q_W-1:0]    q_next;
    logic [Q_W-1:0]    q_reg;
    logic              neg_reg;

    always_comb
    begin
        lo_round = lo_p_reg + (PART_W'(1) << (INT8_SHIFT - 1));
        a_round  = a_reg + (ACC_W'(1) << (Q15_SHIFT - 1));
        if (mode_reg)
        begin
            q_next = (Q_W'(hi_p_reg) << HI_SHIFT) + Q_W'(lo_round >> INT8_SHIFT);
        end
        else
        begin
            q_next = Q_W'(a_round >> Q15_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
        begin
            q_reg   <= q_next;
            neg_reg <= mode_reg ? (acc_neg_reg ^ scale_neg_reg) : acc_neg_reg;
        end
    end

    // read: saturate to the result width
    logic [RES_W-1:0] res_value;
    logic             res_sat;

    always_comb
    begin
        res_value = '0;
        res_sat   = 1'b0;
        if (ok_reg)
        begin
            if (neg_reg)
            begin
                if (q_reg > Q_W'(RES_MIN))
                begin
                    res_value = RES_MIN;
                    res_sat   = 1'b1;
                end
                else
                begin
                    res_value = RES_W'(0) - q_reg[RES_W-1:0];
                end
            end
            else
            begin
                if (q_reg > Q_W'(RES_MAX))
                begin
                    res_value = RES_MAX;
                    res_sat   = 1'b1;
                end
                else
                begin
                    res_value = q_reg[RES_W-1:0];
                end
            end
            res_sat = res_sat | mark_reg;
        end
    end

    // output register
    logic             out_valid_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [RES_W-1:0] out_value_reg;
    logic             out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_col_reg   <= col_reg;
            out_value_reg <= res_value;
            out_sat_reg   <= res_sat;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign result_column   = out_col_reg;
    assign result_value    = out_value_reg;
    assign saturated       = out_sat_reg;

endmodule

`default_nettype wire

// File: rtl/core/quantized_matrix_vector_mac_top.sv
`default_nettype none

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------------------------
// input     | in        | in_valid / in_ready  | command, column, x_value, weight_value,
//           |           |                      | first_row, column_scale
// result    | out       | out_valid / out_ready| result_column, result_value, saturated
// config    | in        | cfg_we (no wait)     | cfg_wdata = weight_is_int8
//
// one transaction at a time: an accumulate goes through accept, multiply and
// read-modify-write of the accumulator ram, a read through accept, magnitude,
// split scale multiply, round, and saturate into the output register
// the sequence is set by the registered read and the later write of the accumulator ram
// and the 48 x 24 scale product taken as two 24 x 24 partial products
// a read waits in its last cycle while the output register still holds an untaken
// result; accumulates go on regardless
// reset clears control state and sets int8 mode; accumulator ram is not cleared

module quantized_matrix_vector_mac_top #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    // input transactions
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [qmvm_pkg::COL_W-1:0]          column,
    input  logic signed [qmvm_pkg::X_W-1:0]     x_value,
    input  logic signed [qmvm_pkg::WGT_W-1:0]   weight_value,
    input  logic                                first_row,
    input  logic signed [qmvm_pkg::SCALE_W-1:0] column_scale,
    // result transactions
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [qmvm_pkg::COL_W-1:0]          result_column,
    output logic signed [qmvm_pkg::RES_W-1:0]   result_value,
    output logic                                saturated
);

    import qmvm_pkg::*;

    // command and status between sequencer and datapath
    qmvm_cmd_t    cmd;
    qmvm_status_t status;

    // sequencer: idle, accumulate path, read path
    qmvm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // datapath: item registers, accumulator ram, multiply, round, saturate, output register
    qmvm_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .column        (column),
        .x_value       (x_value),
        .weight_value  (weight_value),
        .first_row     (first_row),
        .column_scale  (column_scale),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .result_column (result_column),
        .result_value  (result_value),
        .saturated     (saturated)
    );

endmodule

`default_nettype wire

// File: rtl/core/qmvm_checker.sv
`default_nettype none

module qmvm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [qmvm_pkg::COL_W-1:0]         result_column,
    input logic signed [qmvm_pkg::RES_W-1:0]  result_value,
    input logic                               saturated
);

    // after an accepted transaction the block is busy and holds input ready low
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready
    ) else $error("input ready too soon after accept");

    // a new result comes only at the end of a busy read sequence
    a_result_after_read: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (!$past(in_ready) && !$past(in_ready, 2) && !$past(in_ready, 3))
    ) else $error("result appeared without a read sequence");

    // a stalled result holds
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(result_value) && $stable(result_column) && $stable(saturated))
    ) else $error("stalled result changed");

endmodule

bind quantized_matrix_vector_mac_top qmvm_checker u_checker (.*);

`default_nettype wire

// File: bench/tb_quantized_matrix_vector_mac_top.sv
`timescale 1ns / 100ps

module tb_quantized_matrix_vector_mac_top;

    import qmvm_pkg::*;

    localparam int COLUMN_COUNT  = 4096;
    // a short run of full-scale Q1.15 products on two columns, one of each sign
    localparam int SOAK_ADDS     = 8;
    // accumulates give no result; this covers one still in flight after the last read
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 140;
    localparam int CYCLE_LIMIT   = 4000000;

    localparam logic MODE_INT8 = 1'b1;
    localparam logic MODE_Q15  = 1'b0;

    // expected column results, worked out from a private copy of the accumulator table
    class column_accumulator_tracker;
        typedef struct packed {
            logic [COL_W-1:0]        col;
            logic signed [RES_W-1:0] value;
            logic                    sat;
        } column_result_t;

        logic signed [ACC_W-1:0] acc_table [COLUMN_COUNT];
        bit                      overflow_mark [COLUMN_COUNT];
        bit                      int8_mode;
        column_result_t          awaited_results [$];
        int                      mismatch_count;

        function new();
            int8_mode      = 1'b1;
            mismatch_count = 0;
        endfunction

        function void accept_item(input logic cmd, input logic [COL_W-1:0] col,
                                  input logic signed [X_W-1:0] xv,
                                  input logic signed [WGT_W-1:0] wv, input logic first,
                                  input logic signed [SCALE_W-1:0] scale);
            logic signed [WGT_W-1:0] wt;
            logic signed [PROD_W-1:0] prod;
            logic signed [ACC_W:0]   sum;
            logic [ACC_W-1:0]        acc_mag;
            logic [SCALE_W-1:0]      scale_mag;
            logic [71:0]             q;
            logic                    neg;
            logic                    clipped;
            column_result_t          res;
            if (cmd == CMD_ACCUMULATE) begin
                wt = wv;
                if (int8_mode) begin
                    if (wt > INT8_MAX)
                        wt = INT8_MAX;
                    else if (wt < INT8_MIN)
                        wt = INT8_MIN;
                end
                prod = xv * wt;
                if (first) begin
                    acc_table[col]     = ACC_W'(prod);
                    overflow_mark[col] = 1'b0;
                end
                else begin
                    sum = (ACC_W+1)'(acc_table[col]) + (ACC_W+1)'(prod);
                    if (sum[ACC_W:ACC_W-1] == 2'b01) begin
                        sum                = {2'b00, {(ACC_W-1){1'b1}}};
                        overflow_mark[col] = 1'b1;
                    end
                    else if (sum[ACC_W:ACC_W-1] == 2'b10) begin
                        sum                = {2'b11, {(ACC_W-1){1'b0}}};
                        overflow_mark[col] = 1'b1;
                    end
                    acc_table[col] = sum[ACC_W-1:0];
                end
                return;
            end
            neg     = acc_table[col][ACC_W-1];
            acc_mag = neg ? -acc_table[col] : acc_table[col];
            if (int8_mode) begin
                scale_mag = scale[SCALE_W-1] ? -scale : scale;
                q   = {24'b0, acc_mag} * {48'b0, scale_mag};
                q   = (q + 72'd131072) >> INT8_SHIFT;
                neg = neg ^ scale[SCALE_W-1];
            end
            else begin
                q = ({24'b0, acc_mag} + 72'd1024) >> Q15_SHIFT;
            end
            clipped = overflow_mark[col];
            if (neg && q > 72'h8000_0000) begin
                q       = 72'h8000_0000;
                clipped = 1'b1;
            end
            else if (!neg && q > 72'h7FFF_FFFF) begin
                q       = 72'h7FFF_FFFF;
                clipped = 1'b1;
            end
            res.col   = col;
            res.value = neg ? -q[RES_W-1:0] : q[RES_W-1:0];
            res.sat   = clipped;
            awaited_results.push_back(res);
        endfunction

        function void check_column_result(input logic [COL_W-1:0] col,
                                          input logic signed [RES_W-1:0] value,
                                          input logic sat);
            column_result_t want;
            if (awaited_results.size() == 0) begin
                $error("result for column %0d with no read waiting", col);
                mismatch_count++;
                return;
            end
            want = awaited_results.pop_front();
            if (col !== want.col) begin
                $error("result_column: expected %0d, actual %0d", want.col, col);
                mismatch_count++;
            end
            if (value !== want.value) begin
                $error("result_value: expected %0d, actual %0d", want.value, value);
                mismatch_count++;
            end
            if (sat !== want.sat) begin
                $error("saturated: expected %0b, actual %0b", want.sat, sat);
                mismatch_count++;
            end
        endfunction
    endclass

    // dut signals; the driven inputs are known from time zero
    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_we       = 1'b0;
    logic                      cfg_wdata    = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    logic                      command      = CMD_ACCUMULATE;
    logic [COL_W-1:0]          column       = '0;
    logic signed [X_W-1:0]     x_value      = '0;
    logic signed [WGT_W-1:0]   weight_value = '0;
    logic                      first_row    = 1'b0;
    logic signed [SCALE_W-1:0] column_scale = '0;
    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    logic [COL_W-1:0]          result_column;
    logic signed [RES_W-1:0]   result_value;
    logic                      saturated;

    column_accumulator_tracker tracker = new();

    // columns that got a first row; only these may be added to or read
    bit               col_written [COLUMN_COUNT];
    logic [COL_W-1:0] written_list [$];

    bit sender_calm   = 1'b0;
    bit hold_request  = 1'b0;
    int cycle_count   = 0;

    quantized_matrix_vector_mac_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .column        (column),
        .x_value       (x_value),
        .weight_value  (weight_value),
        .first_row     (first_row),
        .column_scale  (column_scale),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_column (result_column),
        .result_value  (result_value),
        .saturated     (saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check each accepted transaction, then pick the next ready
    // mostly short stalls, a few long ones, calm stretches with ready held high,
    // and one long hold-off on request so the block backs up into its input
    int stall_left = 0;
    int calm_left  = 0;
    int hold_left  = 0;
    always @(posedge clk)
    begin
        int r;
        if (rst_n && out_valid && out_ready)
            tracker.check_column_result(result_column, result_value, saturated);
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
            if (calm_left > 0) begin
                calm_left--;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    calm_left = $urandom_range(50, 200);
                else if (r < 25)
                    stall_left = $urandom_range(1, 3);
                else if (r < 28)
                    stall_left = $urandom_range(20, 60);
            end
        end
    end

    // gap before the next input transaction
    function automatic int sender_gap();
        int r;
        if (sender_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COL_W-1:0] pick_column();
        if ($urandom_range(0, 1) == 0)
            return COL_W'($urandom_range(0, 7));
        return COL_W'($urandom);
    endfunction

    // in int8 mode most weights stay in range, the rest exercise the clamp
    function automatic logic signed [WGT_W-1:0] random_weight();
        if (tracker.int8_mode && $urandom_range(0, 4) != 0)
            return WGT_W'($urandom_range(0, 255)) - 16'sd128;
        return WGT_W'($urandom);
    endfunction

    function automatic logic signed [SCALE_W-1:0] random_scale();
        case ($urandom_range(0, 9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            default: return SCALE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [COL_W-1:0] col,
                             input logic signed [X_W-1:0] xv,
                             input logic signed [WGT_W-1:0] wv, input logic first,
                             input logic signed [SCALE_W-1:0] scale, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        column       <= col;
        x_value      <= xv;
        weight_value <= wv;
        first_row    <= first;
        column_scale <= scale;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        tracker.accept_item(cmd, col, xv, wv, first, scale);
        if (cmd == CMD_ACCUMULATE && first && !col_written[col]) begin
            col_written[col] = 1'b1;
            written_list.push_back(col);
        end
    endtask

    task automatic accumulate(input logic [COL_W-1:0] col, input logic signed [X_W-1:0] xv,
                              input logic signed [WGT_W-1:0] wv, input logic first,
                              input int gap);
        send_item(CMD_ACCUMULATE, col, xv, wv, first, SCALE_W'($urandom), gap);
    endtask

    // the x, weight and first-row fields are don't-care on a read, so they toggle freely
    task automatic read_column(input logic [COL_W-1:0] col,
                               input logic signed [SCALE_W-1:0] scale, input int gap);
        send_item(CMD_READ, col, X_W'($urandom), WGT_W'($urandom), 1'($urandom), scale, gap);
    endtask

    // stop offering input until every read has come back and the pipeline is empty
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we            <= 1'b0;
        tracker.int8_mode = mode;
    endtask

    // mostly complete column passes (first row, further rows, read) with random
    // content; the rest is stray accumulates and reads of already written columns
    task automatic run_phase(input int quota);
        int               sent;
        int               kind;
        int               rows;
        int               k;
        bit               heavy;
        logic             heavy_sign;
        logic [COL_W-1:0] col;
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                col        = pick_column();
                // heavy passes repeat full-scale products of one sign to drive
                // the scaled result into saturation
                heavy      = ($urandom_range(0, 9) == 0);
                heavy_sign = 1'($urandom);
                rows       = heavy ? $urandom_range(24, 48) : $urandom_range(1, 6);
                for (k = 0; k < rows; k++) begin
                    if (heavy)
                        accumulate(col, 16'sh8000, heavy_sign ? 16'sh8000 : 16'sh7FFF,
                                   k == 0, sender_gap());
                    else
                        accumulate(col, X_W'($urandom), random_weight(), k == 0,
                                   sender_gap());
                end
                read_column(col, random_scale(), sender_gap());
                if ($urandom_range(0, 4) == 0)
                    read_column(col, random_scale(), sender_gap());
                sent += rows + 1;
            end
            else if (kind < 85) begin
                col = COL_W'($urandom);
                accumulate(col, X_W'($urandom), random_weight(),
                           col_written[col] ? 1'($urandom) : 1'b1, sender_gap());
                sent++;
            end
            else if (written_list.size() != 0) begin
                read_column(written_list[$urandom_range(0, written_list.size() - 1)],
                            random_scale(), sender_gap());
                sent++;
            end
        end
    endtask

    initial
    begin
        int i;
        int p;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // int8 mode from reset: weight clamp at both ends, scale extremes and zero
        accumulate(12'd0, 16'sh8000, 16'sh8000, 1'b1, sender_gap());
        accumulate(12'd0, 16'sh7FFF, 16'sh7FFF, 1'b0, sender_gap());
        read_column(12'd0, 24'sh7FFFFF, sender_gap());
        read_column(12'd0, 24'sh800000, sender_gap());
        read_column(12'd0, 24'sh000000, sender_gap());
        accumulate(12'd4095, 16'sh7FFF, 16'shFF80, 1'b1, sender_gap());
        read_column(12'd4095, 24'sh800000, sender_gap());
        // rounding of exact halves away from zero, and just below a half
        accumulate(12'd1, 16'sh0001, 16'sh0001, 1'b1, sender_gap());
        read_column(12'd1, 24'sh020000, sender_gap());
        read_column(12'd1, 24'sh01FFFF, sender_gap());
        accumulate(12'd2, 16'shFFFF, 16'sh0001, 1'b1, sender_gap());
        read_column(12'd2, 24'sh020000, sender_gap());
        // zero accumulator with a negative scale
        accumulate(12'd3, 16'sh0000, 16'sh0000, 1'b1, sender_gap());
        read_column(12'd3, 24'sh800000, sender_gap());

        // Q1.15 mode: a column stored in int8 mode is read with the new conversion
        write_mode(MODE_Q15);
        read_column(12'd0, random_scale(), sender_gap());
        accumulate(12'd4, 16'sh0400, 16'sh0001, 1'b1, sender_gap());
        read_column(12'd4, random_scale(), sender_gap());
        accumulate(12'd5, 16'sh03FF, 16'sh0001, 1'b1, sender_gap());
        read_column(12'd5, random_scale(), sender_gap());
        accumulate(12'd6, 16'shFC00, 16'sh0001, 1'b1, sender_gap());
        read_column(12'd6, random_scale(), sender_gap());
        accumulate(12'd7, 16'sh8000, 16'sh8000, 1'b1, sender_gap());
        read_column(12'd7, random_scale(), sender_gap());

        // repeated full-scale products, one column rising and the other falling,
        // back to back with no gaps
        accumulate(12'd100, 16'sh8000, 16'sh8000, 1'b1, 0);
        accumulate(12'd101, 16'sh8000, 16'sh7FFF, 1'b1, 0);
        for (i = 0; i < SOAK_ADDS; i++) begin
            accumulate(12'd100, 16'sh8000, 16'sh8000, 1'b0, 0);
            accumulate(12'd101, 16'sh8000, 16'sh7FFF, 1'b0, 0);
        end
        read_column(12'd100, random_scale(), sender_gap());
        read_column(12'd101, random_scale(), sender_gap());
        // the same columns read again in int8 mode, with a negative and a zero scale
        write_mode(MODE_INT8);
        read_column(12'd100, 24'sh800000, sender_gap());
        read_column(12'd101, 24'sh000000, sender_gap());
        // a first row overwrites the column
        accumulate(12'd100, 16'sh0100, 16'sh0002, 1'b1, sender_gap());
        read_column(12'd100, 24'sh7FFFFF, sender_gap());

        // random phases, alternating the weight format
        for (p = 0; p < 6; p++) begin
            write_mode(p % 2 == 0 ? MODE_INT8 : MODE_Q15);
            sender_calm = (p == 3);
            if (p == 2) begin
                // hold results back while reads keep coming, so the input stalls
                hold_request = 1'b1;
                for (i = 0; i < 16; i++)
                    read_column(written_list[$urandom_range(0, written_list.size() - 1)],
                                random_scale(), 0);
            end
            run_phase(PHASE_ITEMS);
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.awaited_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: quantized_matrix_vector_mac_top.f
rtl/core/qmvm_pkg.sv
rtl/core/qmvm_ram.sv
rtl/core/qmvm_ctrl.sv
rtl/core/qmvm_datapath.sv
rtl/core/quantized_matrix_vector_mac_top.sv
rtl/core/qmvm_checker.sv
bench/tb_quantized_matrix_vector_mac_top.sv
